FILE: rtl/core/stick_gesture_arming_fsm_unit_assert.svh
// assertion macros used by the checker
`ifndef STICK_GESTURE_ARMING_FSM_UNIT_ASSERT_SVH
`define STICK_GESTURE_ARMING_FSM_UNIT_ASSERT_SVH

// same-cycle implication
`define SGA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// delayed implication
`define SGA_ASSERT_LATER2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/sga_pkg.sv
package sga_pkg;

   localparam int PULSE_W = 12;
   localparam int TIME_W  = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_THRUST_LOW = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_LOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_HIGH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_MID    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_HOLD   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DISARM_HOLD = 3'd6;

   localparam logic [PULSE_W-1:0] RST_THRUST_LOW = 12'd1000;
   localparam logic [PULSE_W-1:0] RST_YAW_LOW    = 12'd1000;
   localparam logic [PULSE_W-1:0] RST_YAW_HIGH   = 12'd2000;
   localparam logic [PULSE_W-1:0] RST_YAW_MID    = 12'd1500;
   localparam logic [PULSE_W-1:0] RST_TOLERANCE  = 12'd25;
   localparam logic [TIME_W-1:0]  RST_HOLD_US    = 32'd1000000;

   typedef enum logic [1:0] {
      PH_WAITING   = 2'd0,
      PH_ARMING    = 2'd1,
      PH_DISARMING = 2'd2,
      PH_BLOCKING  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [PULSE_W-1:0] thrust_low_center;
      logic [PULSE_W-1:0] yaw_low_center;
      logic [PULSE_W-1:0] yaw_high_center;
      logic [PULSE_W-1:0] yaw_mid_center;
      logic [PULSE_W-1:0] window_tolerance;
      logic [TIME_W-1:0]  arm_hold_us;
      logic [TIME_W-1:0]  disarm_hold_us;
   } cfg_type;

   typedef struct packed {
      logic              armed;
      phase_type         phase;
      logic [TIME_W-1:0] gesture_start;
   } gstate_type;

   // inclusive window test: |v - c| <= tol
   function automatic logic in_window(input logic [PULSE_W-1:0] v,
                                      input logic [PULSE_W-1:0] c,
                                      input logic [PULSE_W-1:0] tol);
      logic [PULSE_W-1:0] d;
      d = (v >= c) ? (v - c) : (c - v);
      return d <= tol;
   endfunction

endpackage

FILE: rtl/core/sga_eval.sv
module sga_eval (
   input  sga_pkg::cfg_type                  cfg,
   input  sga_pkg::gstate_type               cur,
   input  logic [sga_pkg::PULSE_W-1:0]       thrust_pulse,
   input  logic [sga_pkg::PULSE_W-1:0]       yaw_pulse,
   input  logic [sga_pkg::TIME_W-1:0]        now_us,
   output sga_pkg::gstate_type               nxt
);
   import sga_pkg::*;

   logic              thr_low;
   logic              yaw_low;
   logic              yaw_high;
   logic              yaw_mid;
   phase_type         entry_phase;
   logic [TIME_W-1:0] start;
   logic [TIME_W-1:0] elapsed;

   assign thr_low  = in_window(thrust_pulse, cfg.thrust_low_center, cfg.window_tolerance);
   assign yaw_low  = in_window(yaw_pulse, cfg.yaw_low_center, cfg.window_tolerance);
   assign yaw_high = in_window(yaw_pulse, cfg.yaw_high_center, cfg.window_tolerance);
   assign yaw_mid  = in_window(yaw_pulse, cfg.yaw_mid_center, cfg.window_tolerance);

   // releasing the block drops straight into waiting for this same sample
   assign entry_phase = (cur.phase == PH_BLOCKING) ? PH_WAITING : cur.phase;
   assign start   = (entry_phase == PH_WAITING) ? now_us : cur.gesture_start;
   assign elapsed = now_us - start;

   always_comb begin
      nxt = cur;
      if (cur.phase == PH_BLOCKING && !yaw_mid) begin
         nxt = cur;
      end else if (!thr_low) begin
         nxt.phase = PH_WAITING;
      end else begin
         nxt.gesture_start = start;
         if (yaw_low) begin
            if (elapsed >= cfg.arm_hold_us) begin
               nxt.armed = 1'b1;
               nxt.phase = PH_BLOCKING;
            end else begin
               nxt.phase = PH_ARMING;
            end
         end else if (yaw_high) begin
            if (elapsed >= cfg.disarm_hold_us) begin
               nxt.armed = 1'b0;
               nxt.phase = PH_BLOCKING;
            end else begin
               nxt.phase = PH_DISARMING;
            end
         end else begin
            nxt.phase = PH_WAITING;
         end
      end
   end

endmodule

FILE: rtl/core/stick_gesture_arming_fsm_unit.sv
// an input transfer passes the input register, then the result register, before its result transfer
// throughput: one sample per cycle while results are not stalled; the armed/phase/start state
// is set by the window compares and one 32-bit subtract, so samples can follow back to back
// reset: synchronous, active high; clears pipeline valids, disarms, sets phase to waiting
// and restores every configuration register to its default
module stick_gesture_arming_fsm_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [55:0]                        req_tdata,  // thrust_pulse, yaw_pulse, now_us
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,  // is_armed, phase, zero fill
   input  logic                               csr_we,
   input  logic [sga_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sga_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sga_pkg::*;

   cfg_type            cfg_ff;
   gstate_type         state_ff;
   gstate_type         state_in;
   logic               s1_valid_ff;
   logic [PULSE_W-1:0] thrust_ff;
   logic [PULSE_W-1:0] yaw_ff;
   logic [TIME_W-1:0]  now_ff;
   logic               out_valid_ff;
   logic               out_armed_ff;
   phase_type          out_phase_ff;
   logic               advance;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thrust_low_center <= RST_THRUST_LOW;
         cfg_ff.yaw_low_center    <= RST_YAW_LOW;
         cfg_ff.yaw_high_center   <= RST_YAW_HIGH;
         cfg_ff.yaw_mid_center    <= RST_YAW_MID;
         cfg_ff.window_tolerance  <= RST_TOLERANCE;
         cfg_ff.arm_hold_us       <= RST_HOLD_US;
         cfg_ff.disarm_hold_us    <= RST_HOLD_US;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRUST_LOW:  cfg_ff.thrust_low_center <= csr_wdata[PULSE_W-1:0];
            CSR_YAW_LOW:     cfg_ff.yaw_low_center    <= csr_wdata[PULSE_W-1:0];
            CSR_YAW_HIGH:    cfg_ff.yaw_high_center   <= csr_wdata[PULSE_W-1:0];
            CSR_YAW_MID:     cfg_ff.yaw_mid_center    <= csr_wdata[PULSE_W-1:0];
            CSR_TOLERANCE:   cfg_ff.window_tolerance  <= csr_wdata[PULSE_W-1:0];
            CSR_ARM_HOLD:    cfg_ff.arm_hold_us       <= csr_wdata[TIME_W-1:0];
            CSR_DISARM_HOLD: cfg_ff.disarm_hold_us    <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         thrust_ff <= req_tdata[11:0];
         yaw_ff    <= req_tdata[23:12];
         now_ff    <= req_tdata[55:24];
      end
   end

   sga_eval u_eval (
      .cfg          (cfg_ff),
      .cur          (state_ff),
      .thrust_pulse (thrust_ff),
      .yaw_pulse    (yaw_ff),
      .now_us       (now_ff),
      .nxt          (state_in)
   );

   // gesture state and result register, updated when the sample moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.armed         <= 1'b0;
         state_ff.phase         <= PH_WAITING;
         state_ff.gesture_start <= '0;
         out_valid_ff           <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            state_ff <= state_in;
         end
      end
      if (advance && s1_valid_ff) begin
         out_armed_ff <= state_in.armed;
         out_phase_ff <= state_in.phase;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_phase_ff, out_armed_ff};

endmodule

FILE: rtl/core/sga_checker.sv
`include "stick_gesture_arming_fsm_unit_assert.svh"

module sga_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // a stalled result holds
   `SGA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // with no result pending the input side never stalls
   `SGA_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)
   // every accepted sample is followed by a valid result
   `SGA_ASSERT_LATER2(a_rsp_follows, clock, reset, req_tvalid && req_tready, rsp_tvalid)
   // the zero fill above the phase never carries data
   `SGA_ASSERT_IMPLY(a_fill_zero, clock, reset, rsp_tvalid, rsp_tdata[7:3] == 5'b0)

endmodule

bind stick_gesture_arming_fsm_unit sga_checker u_sga_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: sim/stick_gesture_arming_fsm_unit_tb.sv
module stick_gesture_arming_fsm_unit_tb;
   import sga_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic      armed;
      phase_type ph;
   } arm_status_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [55:0]           req_tdata;   // thrust_pulse, yaw_pulse, now_us
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;   // is_armed, phase, zero fill
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cfg_type           gesture_cfg;
   logic              model_armed;
   phase_type         model_phase;
   logic [TIME_W-1:0] model_start;
   logic [TIME_W-1:0] stamp;
   arm_status_type    pending_status_q[$];
   int                errors = 0;
   int                idle_cycles = 0;
   int                ready_hold = 0;
   bit                steady_stream = 0;

   stick_gesture_arming_fsm_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic near_center(input logic [PULSE_W-1:0] v,
                                        input logic [PULSE_W-1:0] c);
      int diff;
      diff = (int'(v) > int'(c)) ? int'(v) - int'(c) : int'(c) - int'(v);
      return diff <= int'(gesture_cfg.window_tolerance);
   endfunction

   // next state of the arming machine for one sample, plus the status it reports
   function automatic void predict_sample(input logic [PULSE_W-1:0] thrust,
                                          input logic [PULSE_W-1:0] yaw,
                                          input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] elapsed;
      logic              go;
      arm_status_type    status;
      go = 1'b1;
      if (model_phase == PH_BLOCKING) begin
         if (near_center(yaw, gesture_cfg.yaw_mid_center))
            model_phase = PH_WAITING;
         else
            go = 1'b0;
      end
      if (go) begin
         if (!near_center(thrust, gesture_cfg.thrust_low_center)) begin
            model_phase = PH_WAITING;
         end else begin
            if (model_phase == PH_WAITING)
               model_start = now;
            // low window wins where the two yaw windows overlap
            if (near_center(yaw, gesture_cfg.yaw_low_center))
               model_phase = PH_ARMING;
            else if (near_center(yaw, gesture_cfg.yaw_high_center))
               model_phase = PH_DISARMING;
            else
               model_phase = PH_WAITING;
            elapsed = now - model_start;
            if (model_phase == PH_ARMING && elapsed >= gesture_cfg.arm_hold_us) begin
               model_armed = 1'b1;
               model_phase = PH_BLOCKING;
            end else if (model_phase == PH_DISARMING &&
                         elapsed >= gesture_cfg.disarm_hold_us) begin
               model_armed = 1'b0;
               model_phase = PH_BLOCKING;
            end
         end
      end
      status.armed = model_armed;
      status.ph = model_phase;
      pending_status_q.push_back(status);
   endfunction

   function automatic int idle_len();
      return ($urandom_range(0, 99) < 75) ? int'($urandom_range(1, 3)) :
                                            int'($urandom_range(4, 24));
   endfunction

   function automatic logic [PULSE_W-1:0] rand_pulse();
      return PULSE_W'($urandom_range(0, 4095));
   endfunction

   // value around a centre, mostly inside its window, sometimes just outside
   function automatic logic [PULSE_W-1:0] jitter(input logic [PULSE_W-1:0] c);
      int tol;
      int off;
      int v;
      tol = int'(gesture_cfg.window_tolerance);
      if ($urandom_range(0, 9) < 8)
         off = int'($urandom_range(0, 2 * tol)) - tol;
      else
         off = $urandom_range(0, 1) ? tol + 1 : -(tol + 1);
      v = int'(c) + off;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return 12'(v);
   endfunction

   function automatic logic [TIME_W-1:0] advance_stamp();
      logic [TIME_W-1:0] hold;
      hold = $urandom_range(0, 1) ? gesture_cfg.arm_hold_us : gesture_cfg.disarm_hold_us;
      if ($urandom_range(0, 19) == 0)
         stamp = $urandom();
      else
         stamp = stamp + $urandom_range(0, (hold >> 1) + 1);
      return stamp;
   endfunction

   task automatic send_sample(input logic [PULSE_W-1:0] thrust,
                              input logic [PULSE_W-1:0] yaw,
                              input logic [TIME_W-1:0] now);
      int gap;
      gap = (steady_stream || $urandom_range(0, 1) == 0) ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {now, yaw, thrust};
      do @(posedge clock); while (!req_tready);
      predict_sample(thrust, yaw, now);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_THRUST_LOW:  gesture_cfg.thrust_low_center = val[PULSE_W-1:0];
         CSR_YAW_LOW:     gesture_cfg.yaw_low_center = val[PULSE_W-1:0];
         CSR_YAW_HIGH:    gesture_cfg.yaw_high_center = val[PULSE_W-1:0];
         CSR_YAW_MID:     gesture_cfg.yaw_mid_center = val[PULSE_W-1:0];
         CSR_TOLERANCE:   gesture_cfg.window_tolerance = val[PULSE_W-1:0];
         CSR_ARM_HOLD:    gesture_cfg.arm_hold_us = val;
         CSR_DISARM_HOLD: gesture_cfg.disarm_hold_us = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_config(input logic [PULSE_W-1:0] thrust_low, yaw_low, yaw_high,
                              yaw_mid, tol, input logic [TIME_W-1:0] arm_hold, disarm_hold);
      write_reg(CSR_THRUST_LOW, CSR_DATA_W'(thrust_low));
      write_reg(CSR_YAW_LOW, CSR_DATA_W'(yaw_low));
      write_reg(CSR_YAW_HIGH, CSR_DATA_W'(yaw_high));
      write_reg(CSR_YAW_MID, CSR_DATA_W'(yaw_mid));
      write_reg(CSR_TOLERANCE, CSR_DATA_W'(tol));
      write_reg(CSR_ARM_HOLD, arm_hold);
      write_reg(CSR_DISARM_HOLD, disarm_hold);
   endtask

   // default registers: hold timing, window edges, blocking release, timestamp wrap
   task automatic test_default_gestures();
      send_sample(12'd1000, 12'd1000, 32'd0);
      send_sample(12'd1000, 12'd1000, 32'd999999);
      send_sample(12'd1000, 12'd1000, 32'd1000000);
      send_sample(12'd1000, 12'd1000, 32'd1000005);
      send_sample(12'd4095, 12'd1526, 32'd1500000);
      send_sample(12'd1000, 12'd1525, 32'd2000000);
      // arm again while armed, then switch straight to disarming on the same start
      send_sample(12'd975, 12'd1000, 32'd3000000);
      send_sample(12'd1025, 12'd1975, 32'd3000010);
      send_sample(12'd1000, 12'd2025, 32'd4000000);
      send_sample(12'd0, 12'd1475, 32'd4000001);
      send_sample(12'd974, 12'd1000, 32'd4000002);
      send_sample(12'd1026, 12'd1000, 32'd4000003);
      send_sample(12'd1000, 12'd1000, 32'hFFFF0000);
      send_sample(12'd1000, 12'd999, 32'hFFFFFFFF);
      send_sample(12'd1001, 12'd1001, 32'hFFFF0000 + 32'd1000000);
      send_sample(12'd1000, 12'd0, 32'd5);
      send_sample(12'd1000, 12'd4095, 32'd6);
      send_sample(12'd1000, 12'd1500, 32'd7);
      send_sample(12'd4095, 12'd1000, 32'd8);
      send_sample(12'd4095, 12'd4095, 32'hFFFFFFFF);
      wait_drain();
   endtask

   // zero tolerance and zero hold, overlapping yaw windows, then the widest settings
   task automatic test_config_extremes();
      load_config(12'd4095, 12'd2048, 12'd2048, 12'd0, 12'd0, 32'd0, 32'd0);
      send_sample(12'd4095, 12'd2048, 32'd100);
      send_sample(12'd4095, 12'd0, 32'd101);
      send_sample(12'd4095, 12'd2048, 32'd102);
      wait_drain();
      write_reg(CSR_YAW_HIGH, 32'd4095);
      send_sample(12'd4095, 12'd0, 32'd103);
      send_sample(12'd4095, 12'd4095, 32'd104);
      send_sample(12'd4094, 12'd0, 32'd105);
      send_sample(12'd4095, 12'd4094, 32'd106);
      wait_drain();
      load_config(12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_sample(12'd4095, 12'd4095, 32'd0);
      send_sample(12'd0, 12'd0, 32'hFFFFFFFE);
      send_sample(12'd0, 12'd0, 32'hFFFFFFFF);
      send_sample(12'd2048, 12'd2048, 32'd1);
      wait_drain();
   endtask

   task automatic run_gesture(output int sent);
      int                 n;
      int                 kind;
      int                 rel;
      logic [PULSE_W-1:0] yaw;
      n = $urandom_range(2, 10);
      kind = $urandom_range(0, 2);
      rel = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) begin
         if (kind == 0 || (kind == 2 && $urandom_range(0, 1) == 0))
            yaw = jitter(gesture_cfg.yaw_low_center);
         else
            yaw = jitter(gesture_cfg.yaw_high_center);
         send_sample(jitter(gesture_cfg.thrust_low_center), yaw, advance_stamp());
      end
      repeat (rel)
         send_sample(jitter(gesture_cfg.thrust_low_center),
                     jitter(gesture_cfg.yaw_mid_center), advance_stamp());
      sent = n + rel;
   endtask

   task automatic test_random_gestures();
      int                count;
      int                r;
      int                sent;
      logic [TIME_W-1:0] hold[2];
      logic [PULSE_W-1:0] tol;
      for (int p = 0; p < 7; p++) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            tol = PULSE_W'($urandom_range(0, 60));
         else if (r < 85)
            tol = PULSE_W'($urandom_range(61, 600));
         else if (r < 95)
            tol = 12'd0;
         else
            tol = 12'd4095;
         for (int k = 0; k < 2; k++) begin
            r = $urandom_range(0, 99);
            hold[k] = (r < 40) ? $urandom_range(0, 3000) : (r < 60) ? 32'd0 :
                      (r < 80) ? $urandom_range(3000, 2000000) :
                      (r < 90) ? $urandom() : 32'hFFFFFFFF;
         end
         load_config(rand_pulse(), rand_pulse(), rand_pulse(), rand_pulse(),
                     tol, hold[0], hold[1]);
         steady_stream = (p == 2);
         stamp = $urandom();
         count = 0;
         while (count < 100) begin
            if ($urandom_range(0, 9) < 8) begin
               run_gesture(sent);
               count += sent;
            end else begin
               send_sample(rand_pulse(), rand_pulse(), $urandom());
               count += 1;
            end
            // hold off the sender until the block has caught up
            if (p == 4 && count >= 50 && count < 62)
               wait_drain();
         end
         wait_drain();
      end
      steady_stream = 0;
   endtask

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady_stream && $urandom_range(0, 3) == 0)
            ready_hold <= idle_len();
      end
   end

   always @(posedge clock) begin
      arm_status_type exp_status;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status_q.size() == 0) begin
            $display("%0t: result transfer with nothing pending, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            exp_status = pending_status_q.pop_front();
            if (rsp_tdata[0] !== exp_status.armed) begin
               $display("%0t: is_armed mismatch, expected %0d actual %0d",
                        $time, exp_status.armed, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[2:1] !== exp_status.ph) begin
               $display("%0t: phase mismatch, expected %0d actual %0d",
                        $time, exp_status.ph, rsp_tdata[2:1]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL stick_gesture_arming_fsm_unit");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      gesture_cfg.thrust_low_center = RST_THRUST_LOW;
      gesture_cfg.yaw_low_center = RST_YAW_LOW;
      gesture_cfg.yaw_high_center = RST_YAW_HIGH;
      gesture_cfg.yaw_mid_center = RST_YAW_MID;
      gesture_cfg.window_tolerance = RST_TOLERANCE;
      gesture_cfg.arm_hold_us = RST_HOLD_US;
      gesture_cfg.disarm_hold_us = RST_HOLD_US;
      model_armed = 1'b0;
      model_phase = PH_WAITING;
      model_start = '0;
      stamp = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_gestures();
      test_config_extremes();
      test_random_gestures();
      wait_drain();
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("PASS stick_gesture_arming_fsm_unit");
      else
         $display("FAIL stick_gesture_arming_fsm_unit");
      $finish;
   end

endmodule

FILE: stick_gesture_arming_fsm_unit.f
+incdir+rtl/core
rtl/core/sga_pkg.sv
rtl/core/sga_eval.sv
rtl/core/stick_gesture_arming_fsm_unit.sv
rtl/core/sga_checker.sv
sim/stick_gesture_arming_fsm_unit_tb.sv
